// ----- hdl/mspd_pkg.sv -----
package mspd_pkg;

  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIV_Q_W  = 48;
  localparam int FRAC_W   = 16;

  localparam logic [14:0] SPEED_PER_COUNT = 15'd31416;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SETPOINT = 3'd0;
  localparam reg_idx_t REG_RADIUS   = 3'd1;
  localparam reg_idx_t REG_FF_GAIN  = 3'd2;
  localparam reg_idx_t REG_P_GAIN   = 3'd3;
  localparam reg_idx_t REG_I_GAIN   = 3'd4;
  localparam reg_idx_t REG_D_GAIN   = 3'd5;
  localparam reg_idx_t REG_I_LIMIT  = 3'd6;
  localparam reg_idx_t REG_INVERT   = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/motor_speed_pid_drive_top.sv -----
// Speed regulator and H-bridge drive for one DC wheel motor. Each item (encoder count,
// time step, link and enable flags) yields one result: wheel speed in signed Q16.16,
// the PWM compare value and the bridge pin levels. One item is worked on at a time;
// an item's six products go in turn through one bit-serial 33-bit multiplier, and
// the bit-serial derivative divider runs alongside the middle products. Gains and
// limits are to be written over the APB port only while the block is idle; the
// block itself does not enforce it.
module motor_speed_pid_drive_top #(
  parameter int PWM_PERIOD    = 14399,
  parameter int COMPARE_SCALE = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] encoder_count,
  input  logic        [31:0] time_step,
  input  logic               link_connected,
  input  logic               drive_enable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] measured_speed,
  output logic        [14:0] duty_compare,
  output logic               dir_a,
  output logic               dir_b,
  output logic               bridge_enabled,
  output logic               drive_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int W = mspd_pkg::MUL_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEAS, ST_ERR, ST_INT, ST_FF, ST_KP, ST_KI, ST_KD, ST_DRV, ST_OUT
  } state_t;

  state_t state;

  logic signed [31:0] setpoint;
  logic        [30:0] radius;
  logic signed [31:0] ff_gain;
  logic signed [31:0] p_gain;
  logic signed [31:0] i_gain;
  logic signed [31:0] d_gain;
  logic        [30:0] i_limit;
  logic               invert;

  logic signed [31:0] enc;
  logic        [31:0] dt;
  logic               conn;
  logic               en;
  logic signed [31:0] meas;
  logic signed [31:0] err;
  logic signed [31:0] integral;
  logic signed [31:0] prev_err;
  logic signed [51:0] sum;
  logic signed [17:0] drive;
  logic               issued;

  logic        [14:0] held_compare;
  logic               held_dir_a;
  logic               held_dir_b;
  logic               held_bridge;

  logic signed [47:0] enc_full;
  logic signed [31:0] target;
  logic signed [W-1:0] mul_a;
  logic        [W-1:0] mul_b;
  logic               mul_start;
  mspd_pkg::unit_stat_t mul_stat;
  logic signed [mspd_pkg::PROD_W-1:0] mul_prod;
  logic signed [49:0] term;
  logic signed [31:0] meas_raw;
  logic signed [31:0] meas_neg;
  logic signed [31:0] err_c;
  logic signed [32:0] diff;
  logic               div_start;
  mspd_pkg::unit_stat_t div_stat;
  logic signed [31:0] deriv;
  logic signed [50:0] integ_c;
  logic signed [50:0] lim_pos;
  logic signed [35:0] drive_q;
  logic signed [35:0] drive_t;
  logic        [16:0] drive_mag;
  logic        [14:0] cmp_val;
  logic               apb_wr;
  logic               mul_state;

  assign enc_full = encoder_count * $signed({1'b0, mspd_pkg::SPEED_PER_COUNT});
  assign target   = conn ? setpoint : 32'sd0;
  assign term     = mul_prod[mspd_pkg::PROD_W-1:mspd_pkg::FRAC_W];

  always_comb begin
    mul_a = W'(enc);
    mul_b = {2'b00, radius};
    case (state)
      ST_INT: begin mul_a = W'(err);     mul_b = {1'b0, dt}; end
      ST_FF:  begin mul_a = W'(ff_gain); mul_b = W'(target); end
      ST_KP:  begin mul_a = W'(p_gain);  mul_b = W'(err); end
      ST_KI:  begin mul_a = W'(i_gain);  mul_b = W'(integral); end
      ST_KD:  begin mul_a = W'(d_gain);  mul_b = W'(deriv); end
      default: begin end
    endcase
  end

  assign mul_state = (state == ST_MEAS) || (state == ST_INT) || (state == ST_FF) ||
                     (state == ST_KP) || (state == ST_KI) || (state == ST_KD);
  assign mul_start = mul_state && !issued && !((state == ST_KD) && div_stat.busy);

  always_comb begin
    meas_raw  = mspd_pkg::sat32(64'(term));
    meas_neg  = mspd_pkg::sat32(-64'(meas_raw));
    err_c     = mspd_pkg::sat32(64'(target) - 64'(meas));
    diff      = 33'(err_c) - 33'(prev_err);
    div_start = (state == ST_ERR);
    integ_c   = 51'(integral) + 51'(term);
    lim_pos   = 51'($signed({1'b0, i_limit}));
    drive_q   = sum[51:16];
    if (sum < 0 && sum[15:0] != '0) drive_t = drive_q + 36'sd1;
    else drive_t = drive_q;
    drive_mag = drive[17] ? 17'(-drive) : 17'(drive);
    cmp_val   = 15'(32'(drive_mag) * COMPARE_SCALE);
  end

  mspd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  mspd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .diff  (diff),
    .dt    (dt),
    .stat  (div_stat),
    .deriv (deriv)
  );

  assign apb_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      radius   <= '0;
      ff_gain  <= '0;
      p_gain   <= '0;
      i_gain   <= '0;
      d_gain   <= '0;
      i_limit  <= '0;
      invert   <= 1'b0;
    end else if (apb_wr) begin
      case (paddr[4:2])
        mspd_pkg::REG_SETPOINT: setpoint <= pwdata;
        mspd_pkg::REG_RADIUS:   radius   <= pwdata[30:0];
        mspd_pkg::REG_FF_GAIN:  ff_gain  <= pwdata;
        mspd_pkg::REG_P_GAIN:   p_gain   <= pwdata;
        mspd_pkg::REG_I_GAIN:   i_gain   <= pwdata;
        mspd_pkg::REG_D_GAIN:   d_gain   <= pwdata;
        mspd_pkg::REG_I_LIMIT:  i_limit  <= pwdata[30:0];
        mspd_pkg::REG_INVERT:   invert   <= pwdata[0];
        default: begin end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mspd_pkg::REG_SETPOINT: prdata = setpoint;
      mspd_pkg::REG_RADIUS:   prdata = {1'b0, radius};
      mspd_pkg::REG_FF_GAIN:  prdata = ff_gain;
      mspd_pkg::REG_P_GAIN:   prdata = p_gain;
      mspd_pkg::REG_I_GAIN:   prdata = i_gain;
      mspd_pkg::REG_D_GAIN:   prdata = d_gain;
      mspd_pkg::REG_I_LIMIT:  prdata = {1'b0, i_limit};
      mspd_pkg::REG_INVERT:   prdata = {31'd0, invert};
      default:                prdata = '0;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      out_valid    <= 1'b0;
      integral     <= '0;
      prev_err     <= '0;
      held_compare <= '0;
      held_dir_a   <= 1'b0;
      held_dir_b   <= 1'b0;
      held_bridge  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      if (mul_start) issued <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            enc   <= mspd_pkg::sat32(64'(enc_full));
            dt    <= time_step;
            conn  <= link_connected;
            en    <= drive_enable;
            state <= ST_MEAS;
          end
        end
        ST_MEAS: begin
          if (mul_stat.done) begin
            issued <= 1'b0;
            meas   <= invert ? meas_neg : meas_raw;
            state  <= ST_ERR;
          end
        end
        ST_ERR: begin
          err      <= err_c;
          prev_err <= err_c;
          sum      <= '0;
          state    <= ST_INT;
        end
        ST_INT: begin
          if (mul_stat.done) begin
            issued <= 1'b0;
            if (integ_c > lim_pos) integral <= 32'(lim_pos);
            else if (integ_c < -lim_pos) integral <= 32'(-lim_pos);
            else integral <= integ_c[31:0];
            state <= ST_FF;
          end
        end
        ST_FF, ST_KP, ST_KI, ST_KD: begin
          if (mul_stat.done) begin
            issued <= 1'b0;
            sum    <= sum + 52'(term);
            case (state)
              ST_FF:   state <= ST_KP;
              ST_KP:   state <= ST_KI;
              ST_KI:   state <= ST_KD;
              default: state <= ST_DRV;
            endcase
          end
        end
        ST_DRV: begin
          if (drive_t > 36'(PWM_PERIOD)) drive <= 18'(PWM_PERIOD);
          else if (drive_t < -36'(PWM_PERIOD)) drive <= -18'(PWM_PERIOD);
          else drive <= drive_t[17:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            measured_speed <= meas;
            drive_status   <= en && (drive == 0);
            state          <= ST_IDLE;
            if (!en) begin
              held_dir_a     <= 1'b0;
              held_dir_b     <= 1'b1;
              held_compare   <= '0;
              dir_a          <= 1'b0;
              dir_b          <= 1'b1;
              duty_compare   <= '0;
              bridge_enabled <= held_bridge;
            end else begin
              held_bridge    <= 1'b1;
              bridge_enabled <= 1'b1;
              if (drive > 0) begin
                held_dir_a   <= 1'b1;
                held_dir_b   <= 1'b0;
                held_compare <= cmp_val;
                dir_a        <= 1'b1;
                dir_b        <= 1'b0;
                duty_compare <= cmp_val;
              end else if (drive < 0) begin
                held_dir_a   <= 1'b0;
                held_dir_b   <= 1'b1;
                held_compare <= cmp_val;
                dir_a        <= 1'b0;
                dir_b        <= 1'b1;
                duty_compare <= cmp_val;
              end else begin
                dir_a        <= held_dir_a;
                dir_b        <= held_dir_b;
                duty_compare <= held_compare;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_MEAS)
    else $error("accepted item did not start the speed product");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(dir_a && dir_b))
    else $error("both bridge inputs high");

  a_kept_implies_bridge: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_status |-> bridge_enabled)
    else $error("zero drive kept without bridge enabled");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> drive <= 18'(PWM_PERIOD) && drive >= -18'(PWM_PERIOD))
    else $error("drive outside PWM period");

endmodule

// ----- hdl/mspd_mul.sv -----
module mspd_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mspd_pkg::MUL_W-1:0]   a,
  input  logic        [mspd_pkg::MUL_W-1:0]   b,
  output mspd_pkg::unit_stat_t                stat,
  output logic signed [mspd_pkg::PROD_W-1:0]  prod
);

  localparam int W = mspd_pkg::MUL_W;

  logic signed [W:0]   hi;
  logic        [W-1:0] lo;
  logic signed [W-1:0] a_r;
  logic        [5:0]   cnt;
  logic                busy;
  logic                done;
  logic signed [W+1:0] addend;
  logic signed [W+1:0] hi_ext;
  logic signed [W+1:0] sum;
  logic        [2*W:0] full;

  // shift-add, one multiplier bit per cycle; the top bit carries negative weight
  always_comb begin
    addend = lo[0] ? {{2{a_r[W-1]}}, a_r} : '0;
    hi_ext = {hi[W], hi};
    if (cnt == 6'(W - 1)) sum = hi_ext - addend;
    else sum = hi_ext + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi   <= '0;
        lo   <= b;
        a_r  <= a;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= sum[W+1:1];
        lo  <= {sum[0], lo[W-1:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign full      = {hi, lo};
  assign prod      = $signed(full[2*W-1:0]);
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hdl/mspd_div.sv -----
module mspd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [32:0]          diff,
  input  logic        [31:0]          dt,
  output mspd_pkg::unit_stat_t        stat,
  output logic signed [31:0]          deriv
);

  localparam int QW = mspd_pkg::DIV_Q_W;

  logic          neg;
  logic [31:0]   rem;
  logic [QW-1:0] q;
  logic [31:0]   d;
  logic [5:0]    cnt;
  logic          busy;
  logic          done;
  logic [32:0]   r2;
  logic          ge;
  logic [32:0]   r2_sub;
  logic [QW-1:0] qn;
  logic [32:0]   mag;

  // restoring division of |diff|*2^16 by dt, one quotient bit per cycle
  always_comb begin
    r2     = {rem, q[QW-1]};
    ge     = r2 >= {1'b0, d};
    r2_sub = r2 - {1'b0, d};
    qn     = {q[QW-2:0], ge};
    mag    = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= diff[32];
        rem <= '0;
        q   <= {mag[31:0], 16'h0000};
        d   <= dt;
        cnt <= '0;
        if (dt == '0) begin
          done <= 1'b1;
          if (diff[32]) deriv <= 32'sh80000000;
          else if (diff != '0) deriv <= 32'sh7fffffff;
          else deriv <= '0;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? r2_sub[31:0] : r2[31:0];
        q   <= qn;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            if (qn >= QW'(64'h80000000)) deriv <= 32'sh80000000;
            else deriv <= -$signed({1'b0, qn[30:0]});
          end else begin
            if (qn > QW'(64'h7fffffff)) deriv <= 32'sh7fffffff;
            else deriv <= $signed(qn[31:0]);
          end
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
